FILE: design/lfu_color_table_cache_top_assert.svh
// ---------------------------------------------------------------------------
// LFU colour table cache assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef LFU_COLOR_TABLE_CACHE_TOP_ASSERT_SVH
`define LFU_COLOR_TABLE_CACHE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define LFU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define LFU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LFU_ASSERT(lbl, prop, msg)
`define LFU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: design/lfuct_pkg.sv
// ---------------------------------------------------------------------------
// LFU colour table cache package
// Key type, stream field widths and the gamma tolerance compare.
// ---------------------------------------------------------------------------
package lfuct_pkg;

    localparam int IN_TDATA_W  = 120;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 16;
    localparam int TOL_W       = 10;
    localparam int SLOT_W      = 8;

    localparam logic [TOL_W-1:0] GAMMA_TOL_RESET = 10'd5;

    localparam logic MODE_LOOKUP      = 1'b0;
    localparam logic MODE_FILL_FAILED = 1'b1;

    typedef struct packed {
        logic signed [15:0] density_value;
        logic [15:0]        gamma_milli;
        logic [8:0]         level_count;
        logic [31:0]        bg_color;
        logic [31:0]        fg_color;
    } key_t;

    function automatic logic key_match(key_t a, key_t b, logic [TOL_W-1:0] tol);
        logic [15:0] diff;
        logic        same;
        same = (a.fg_color == b.fg_color) && (a.bg_color == b.bg_color) &&
               (a.level_count == b.level_count) && (a.density_value == b.density_value);
        diff = (a.gamma_milli >= b.gamma_milli) ? (a.gamma_milli - b.gamma_milli)
                                                : (b.gamma_milli - a.gamma_milli);
        return same && (diff <= {6'd0, tol});
    endfunction

endpackage

FILE: design/lfu_color_table_cache_top.sv
// ---------------------------------------------------------------------------
// LFU colour table cache
// Fully associative key store with least-hits replacement and slot release.
// ---------------------------------------------------------------------------
// After reset the block runs a clearing pass over the valid store and is not
// ready until it ends. A lookup scans the store one entry per cycle through a
// single read port; a hit goes straight to the response state, a miss first
// installs its key in a free or least-hit slot. A fill failed item clears the
// valid bit of its slot, if in range. The block takes one item at a time; a
// finished item waits in the output register while the next one is scanned.

`include "lfu_color_table_cache_top_assert.svh"

module lfu_color_table_cache_top #(
    parameter int ENTRIES  = 256,
    parameter int HIT_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lfuct_pkg::TOL_W-1:0]      cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // fg_color[31:0], bg_color[63:32], level_count[72:64], density_value[88:73],
    // gamma_milli[104:89], failed_slot[112:105], zero[119:113]
    input  logic [lfuct_pkg::IN_TDATA_W-1:0] s_tdata,
    // mode[0]
    input  logic [lfuct_pkg::IN_TUSER_W-1:0] s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // hit[0], slot_index[8:1], evicted[9], zero[15:10]
    output logic [lfuct_pkg::OUT_TDATA_W-1:0] m_tdata
);

    import lfuct_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = AW + 1;
    localparam int FW = (CW > SLOT_W) ? CW : SLOT_W;
    localparam logic [AW-1:0] LAST_SLOT = AW'(ENTRIES - 1);

    localparam logic [2:0] ST_CLEAR   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_SCAN    = 3'd2;
    localparam logic [2:0] ST_INSTALL = 3'd3;
    localparam logic [2:0] ST_RESP    = 3'd4;

    key_t              key_mem [ENTRIES];
    logic [HIT_BITS-1:0] hit_mem [ENTRIES];
    logic              vld_mem [ENTRIES];

    logic [2:0]          state_reg, state_next;
    logic [CW-1:0]       scan_cnt_reg, scan_cnt_next;
    logic                eval_vld_reg, eval_vld_next;
    logic [AW-1:0]       eval_addr_reg, eval_addr_next;
    logic                have_free_reg, have_free_next;
    logic                have_low_reg, have_low_next;
    logic                out_vld_reg, out_vld_next;
    logic [TOL_W-1:0]    tol_reg;

    logic [AW-1:0]       free_slot_reg, free_slot_next;
    logic [AW-1:0]       low_slot_reg, low_slot_next;
    logic [HIT_BITS-1:0] low_hits_reg, low_hits_next;
    key_t                req_key_reg, req_key_next;
    logic                res_hit_reg, res_hit_next;
    logic [SLOT_W-1:0]   res_slot_reg, res_slot_next;
    logic                res_evict_reg, res_evict_next;
    logic                out_hit_reg, out_hit_next;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic                out_evict_reg, out_evict_next;

    key_t                rd_key_reg;
    logic [HIT_BITS-1:0] rd_hit_reg;
    logic                rd_vld_reg;

    logic [AW-1:0]       rd_addr;
    logic                vld_we, vld_wdata;
    logic [AW-1:0]       vld_waddr;
    logic                hit_we;
    logic [AW-1:0]       hit_waddr;
    logic [HIT_BITS-1:0] hit_wdata;
    logic                key_we;
    logic [AW-1:0]       install_slot;
    logic                key_hit;
    logic                in_accept;
    key_t                in_key;
    logic [SLOT_W-1:0]   in_fslot;

    assign in_key.fg_color      = s_tdata[31:0];
    assign in_key.bg_color      = s_tdata[63:32];
    assign in_key.level_count   = s_tdata[72:64];
    assign in_key.density_value = s_tdata[88:73];
    assign in_key.gamma_milli   = s_tdata[104:89];
    assign in_fslot             = s_tdata[112:105];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = {6'd0, out_evict_reg, out_slot_reg, out_hit_reg};

    assign key_hit      = rd_vld_reg && key_match(rd_key_reg, req_key_reg, tol_reg);
    assign install_slot = have_free_reg ? free_slot_reg : low_slot_reg;

    always_comb
    begin
        state_next     = state_reg;
        scan_cnt_next  = scan_cnt_reg;
        eval_vld_next  = 1'b0;
        eval_addr_next = eval_addr_reg;
        have_free_next = have_free_reg;
        have_low_next  = have_low_reg;
        free_slot_next = free_slot_reg;
        low_slot_next  = low_slot_reg;
        low_hits_next  = low_hits_reg;
        req_key_next   = req_key_reg;
        res_hit_next   = res_hit_reg;
        res_slot_next  = res_slot_reg;
        res_evict_next = res_evict_reg;
        out_vld_next   = out_vld_reg && !m_tready;
        out_hit_next   = out_hit_reg;
        out_slot_next  = out_slot_reg;
        out_evict_next = out_evict_reg;
        rd_addr        = scan_cnt_reg[AW-1:0];
        vld_we         = 1'b0;
        vld_waddr      = scan_cnt_reg[AW-1:0];
        vld_wdata      = 1'b0;
        hit_we         = 1'b0;
        hit_waddr      = eval_addr_reg;
        hit_wdata      = (rd_hit_reg == {HIT_BITS{1'b1}}) ? rd_hit_reg
                                                          : rd_hit_reg + HIT_BITS'(1);
        key_we         = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                vld_we        = 1'b1;
                scan_cnt_next = scan_cnt_reg + CW'(1);
                if (scan_cnt_reg[AW-1:0] == LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_tuser[0] == MODE_FILL_FAILED)
                    begin
                        vld_we         = (FW'(in_fslot) < FW'(ENTRIES));
                        vld_waddr      = AW'(FW'(in_fslot));
                        res_hit_next   = 1'b0;
                        res_slot_next  = in_fslot;
                        res_evict_next = 1'b0;
                        state_next     = ST_RESP;
                    end
                    else
                    begin
                        req_key_next   = in_key;
                        scan_cnt_next  = '0;
                        have_free_next = 1'b0;
                        have_low_next  = 1'b0;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_cnt_reg < CW'(ENTRIES))
                begin
                    scan_cnt_next  = scan_cnt_reg + CW'(1);
                    eval_vld_next  = 1'b1;
                    eval_addr_next = scan_cnt_reg[AW-1:0];
                end
                if (eval_vld_reg)
                begin
                    if (!rd_vld_reg)
                    begin
                        if (!have_free_reg)
                        begin
                            have_free_next = 1'b1;
                            free_slot_next = eval_addr_reg;
                        end
                    end
                    else if (!key_hit && (!have_low_reg || rd_hit_reg < low_hits_reg))
                    begin
                        have_low_next = 1'b1;
                        low_hits_next = rd_hit_reg;
                        low_slot_next = eval_addr_reg;
                    end

                    if (key_hit)
                    begin
                        hit_we         = 1'b1;
                        res_hit_next   = 1'b1;
                        res_slot_next  = SLOT_W'(eval_addr_reg);
                        res_evict_next = 1'b0;
                        eval_vld_next  = 1'b0;
                        state_next     = ST_RESP;
                    end
                    else if (eval_addr_reg == LAST_SLOT)
                    begin
                        eval_vld_next = 1'b0;
                        state_next    = ST_INSTALL;
                    end
                end
            end
            ST_INSTALL:
            begin
                key_we         = 1'b1;
                hit_we         = 1'b1;
                hit_waddr      = install_slot;
                hit_wdata      = HIT_BITS'(1);
                vld_we         = 1'b1;
                vld_waddr      = install_slot;
                vld_wdata      = 1'b1;
                res_hit_next   = 1'b0;
                res_slot_next  = SLOT_W'(install_slot);
                res_evict_next = !have_free_reg;
                state_next     = ST_RESP;
            end
            ST_RESP:
            begin
                if (!out_vld_reg || m_tready)
                begin
                    out_vld_next   = 1'b1;
                    out_hit_next   = res_hit_reg;
                    out_slot_next  = res_slot_reg;
                    out_evict_next = res_evict_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            scan_cnt_reg  <= '0;
            eval_vld_reg  <= 1'b0;
            have_free_reg <= 1'b0;
            have_low_reg  <= 1'b0;
            out_vld_reg   <= 1'b0;
            tol_reg       <= GAMMA_TOL_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            eval_vld_reg  <= eval_vld_next;
            have_free_reg <= have_free_next;
            have_low_reg  <= have_low_next;
            out_vld_reg   <= out_vld_next;
            if (cfg_we)
            begin
                tol_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        eval_addr_reg <= eval_addr_next;
        free_slot_reg <= free_slot_next;
        low_slot_reg  <= low_slot_next;
        low_hits_reg  <= low_hits_next;
        req_key_reg   <= req_key_next;
        res_hit_reg   <= res_hit_next;
        res_slot_reg  <= res_slot_next;
        res_evict_reg <= res_evict_next;
        out_hit_reg   <= out_hit_next;
        out_slot_reg  <= out_slot_next;
        out_evict_reg <= out_evict_next;
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[install_slot] <= req_key_reg;
        end
        rd_key_reg <= key_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (hit_we)
        begin
            hit_mem[hit_waddr] <= hit_wdata;
        end
        rd_hit_reg <= hit_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (vld_we)
        begin
            vld_mem[vld_waddr] <= vld_wdata;
        end
        rd_vld_reg <= vld_mem[rd_addr];
    end

    `LFU_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")
    `LFU_ASSERT(a_result_from_resp, $rose(m_tvalid) |-> $past(state_reg) == ST_RESP, "stray item")
    `LFU_ASSERT_NEXT(a_hit_ends_scan, state_reg == ST_SCAN && eval_vld_reg && key_hit,
                     state_reg == ST_RESP && res_hit_reg, "hit not reported")
    `LFU_ASSERT(a_hit_no_evict, m_tvalid |-> !(m_tdata[0] && m_tdata[9]), "hit with eviction")
    `LFU_ASSERT(a_scan_bound, scan_cnt_reg <= CW'(ENTRIES), "scan counter overrun")

endmodule
